>>> hw/rtl/pirl_pkg.sv
// Shared word types and operation codes for the positional list unit.
package pirl_pkg;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  position;
    logic [31:0] item_value;
  } req_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [4:0]  element_count;
  } rsp_word_t;

  // Broadcast to every cell: commit the operation this cycle, and which one.
  typedef struct packed {
    logic       commit;
    logic [1:0] func;
  } cell_cmd_t;

endpackage

>>> hw/rtl/pirl_cell.sv
// One list slot: holds an entry and takes it from a neighbor or the new word.
module pirl_cell import pirl_pkg::*; #(
  parameter int ITEM_WIDTH = 32,
  parameter int CMP_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CMP_W-1:0]      pos,
  input  logic [CMP_W-1:0]      count,
  input  logic [ITEM_WIDTH-1:0] new_value,
  input  logic [ITEM_WIDTH-1:0] left_value,
  input  logic [ITEM_WIDTH-1:0] right_value,
  output logic [ITEM_WIDTH-1:0] value
);

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [ITEM_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    if (cmd.commit) begin
      case (cmd.func)
        FUNC_APPEND: begin
          if (IDX == count) value_next = new_value;
        end
        FUNC_INSERT: begin
          if (IDX == pos) value_next = new_value;
          else if (IDX > pos) value_next = left_value;
        end
        FUNC_REMOVE: begin
          if (IDX >= pos) value_next = right_value;
        end
        default: value_next = value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hw/rtl/positional_insert_remove_list_unit.sv
// Top level of the positional list unit: cell chain, count and response register.
// The response word for an accepted request word is registered.
// Throughput: one request word per cycle; every cell shifts or loads in the
// same cycle, so the only limit is the single response register draining.
// Reset clears the element count and the response valid; entry cells are not
// cleared, since a slot is never read before it is written.
module positional_insert_remove_list_unit import pirl_pkg::*; #(
  parameter int LIST_CAPACITY = 16,
  parameter int ITEM_WIDTH    = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int IDX_W = $clog2(LIST_CAPACITY);
  localparam logic [CMP_W-1:0] CAP = CMP_W'(LIST_CAPACITY);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [63:0]           in_wide;
  logic [ITEM_WIDTH-1:0] new_value;
  logic [63:0]           rd_wide;
  logic                  accept;
  logic                  op_ok;
  cell_cmd_t             cmd;
  rsp_word_t             rsp_next;

  logic [ITEM_WIDTH-1:0] cell_q [LIST_CAPACITY];

  // Hold the request while a finished response is still waiting downstream.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(count);
  assign in_wide   = 64'(req.item_value);
  assign new_value = in_wide[ITEM_WIDTH-1:0];

  // Decide success against the count before the operation.
  always_comb begin
    case (req.func)
      FUNC_APPEND: op_ok = cnt_ext < CAP;
      FUNC_INSERT: op_ok = (pos_ext <= cnt_ext) && (cnt_ext < CAP);
      FUNC_REMOVE: op_ok = pos_ext < cnt_ext;
      default:     op_ok = pos_ext < cnt_ext;
    endcase
  end

  assign cmd.commit = accept && op_ok;
  assign cmd.func   = req.func;

  // Advance the count on a successful append, insert or remove.
  always_comb begin
    count_next = count;
    if (op_ok) begin
      case (req.func)
        FUNC_APPEND: count_next = count + CNT_W'(1);
        FUNC_INSERT: count_next = count + CNT_W'(1);
        FUNC_REMOVE: count_next = count - CNT_W'(1);
        default:     count_next = count;
      endcase
    end
  end

  // Chain of cells: each takes from its left neighbor on insert and from its
  // right neighbor on remove. The ends close on the new word and on itself.
  for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_value;
    logic [ITEM_WIDTH-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = new_value;
    end else begin : g_mid_l
      assign left_value = cell_q[i-1];
    end

    if (i == LIST_CAPACITY - 1) begin : g_last
      assign right_value = cell_q[i];
    end else begin : g_mid_r
      assign right_value = cell_q[i+1];
    end

    pirl_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .CMP_W      (CMP_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos_ext),
      .count       (cnt_ext),
      .new_value   (new_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_q[i])
    );
  end

  // Read tap: only used when the position lies below the count.
  assign rd_wide = 64'(cell_q[pos_ext[IDX_W-1:0]]);

  always_comb begin
    rsp_next.ok            = op_ok;
    rsp_next.read_value    = (op_ok && req.func == FUNC_READ) ? rd_wide[31:0] : 32'd0;
    rsp_next.element_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Load the response word with each accepted request; hold it while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> sim/tb_positional_insert_remove_list_unit.sv
// Self-checking testbench for the positional list unit: directed and random list operations.
`timescale 1ns / 100ps

module tb_positional_insert_remove_list_unit;
  import pirl_pkg::*;

  localparam int LIST_CAPACITY = 16;
  localparam int RANDOM_OPS    = 1350;
  localparam int CYCLE_LIMIT   = 500000;
  // The unit answers in the cycle after it takes a word; leave some slack at the end.
  localparam int TAIL_CYCLES   = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  // Operations still to be sent, and the result words owed by the unit, oldest first.
  req_word_t ops_to_send[$];
  rsp_word_t results_owed[$];

  // Shadow copy of the list, advanced once per accepted request word.
  logic [31:0] shadow_entries [0:LIST_CAPACITY-1];
  int          shadow_count = 0;

  // Element count as seen while building the stimulus, used to aim positions.
  int plan_count = 0;
  int mismatches = 0;
  int cycle_count = 0;

  positional_insert_remove_list_unit #(
    .LIST_CAPACITY(LIST_CAPACITY),
    .ITEM_WIDTH   (32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Apply one list operation to the shadow list and return the word the unit owes for it.
  // A refused operation leaves the list untouched; read_value is zero unless a read succeeds.
  function automatic rsp_word_t list_apply(input req_word_t op);
    rsp_word_t res;
    int        i;
    res = '0;
    case (op.func)
      FUNC_APPEND: begin
        if (shadow_count < LIST_CAPACITY) begin
          shadow_entries[shadow_count] = op.item_value;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      FUNC_INSERT: begin
        // Inserting at the current count behaves as an append.
        if (op.position <= shadow_count && shadow_count < LIST_CAPACITY) begin
          for (i = shadow_count; i > op.position; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[op.position] = op.item_value;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (op.position < shadow_count) begin
          for (i = op.position; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (op.position < shadow_count) begin
          res.read_value = shadow_entries[op.position];
          res.ok = 1'b1;
        end
      end
    endcase
    res.element_count = shadow_count[4:0];
    return res;
  endfunction

  // Idle length for either side: mostly none, some short, a few long; none in a calm stretch.
  function automatic int pick_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm)
      return 0;
    if (r < 70)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Queue one operation and track the count it leaves behind, so later positions can be aimed.
  task automatic queue_op(input logic [1:0] f, input int pos, input logic [31:0] v);
    req_word_t w;
    w.func       = f;
    w.position   = pos[4:0];
    w.item_value = v;
    ops_to_send.push_back(w);
    case (f)
      FUNC_APPEND: if (plan_count < LIST_CAPACITY) plan_count++;
      FUNC_INSERT: if (pos <= plan_count && plan_count < LIST_CAPACITY) plan_count++;
      FUNC_REMOVE: if (pos < plan_count) plan_count--;
      default: ;
    endcase
  endtask

  // Driver: predict each accepted word, hold a stalled word, then advance after an idle gap.
  always @(posedge clk) begin : driver
    int gap;
    bit calm;
    if (rst) begin
      req_valid <= 1'b0;
      gap = 0;
    end else begin
      if (req_valid && !req_stall)
        results_owed.push_back(list_apply(req));
      if (!req_valid || !req_stall) begin
        if ($urandom_range(0, 63) == 0)
          calm = !calm;
        if (gap > 0) begin
          gap--;
          req_valid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          req <= ops_to_send.pop_front();
          req_valid <= 1'b1;
          gap = pick_idle(calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result word against the oldest owed one, and stall at random.
  always @(posedge clk) begin : monitor
    int        hold;
    bit        calm;
    rsp_word_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (results_owed.size() == 0) begin
          $error("result word with none owed: %p", rsp);
          mismatches++;
        end else begin
          want = results_owed.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
            mismatches++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            mismatches++;
          end
          if (rsp.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d", want.element_count,
                   rsp.element_count);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0)
        calm = !calm;
      if (hold > 0) begin
        hold--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        hold = pick_idle(calm);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL positional_insert_remove_list_unit");
      $finish;
    end
  end

  initial begin
    int          n;
    int          k;
    int          r;
    int          mode;
    int          span;
    int          pos;
    logic [1:0]  f;
    logic [31:0] v;

    // Directed: every refusal on an empty list first.
    queue_op(FUNC_READ,   0, 32'h0);
    queue_op(FUNC_REMOVE, 0, 32'h0);
    queue_op(FUNC_INSERT, 1, 32'h1234_5678);      // beyond the count
    queue_op(FUNC_INSERT, 0, 32'hFFFF_FFFF);
    queue_op(FUNC_APPEND, 31, 32'h0000_0000);     // append ignores the position
    queue_op(FUNC_READ,   31, 32'h0);             // largest position field
    queue_op(FUNC_INSERT, 2, 32'hA5A5_A5A5);      // position equal to the count
    queue_op(FUNC_READ,   1, 32'h0);
    // Fill to capacity through the front, the middle and the end.
    for (k = 0; k < 13; k++) begin
      v = (k == 6) ? 32'h5A5A_5A5A : $urandom;
      if (k % 3 == 0)
        queue_op(FUNC_INSERT, 0, v);
      else if (k % 3 == 1)
        queue_op(FUNC_INSERT, plan_count / 2, v);
      else
        queue_op(FUNC_APPEND, 0, v);
    end
    // Full list: both growth operations refused, removal past the end refused.
    queue_op(FUNC_APPEND, 0, 32'hDEAD_BEEF);
    queue_op(FUNC_INSERT, 16, 32'hDEAD_BEEF);
    queue_op(FUNC_REMOVE, 16, 32'h0);
    queue_op(FUNC_REMOVE, 0, 32'h0);
    queue_op(FUNC_READ,   15, 32'h0);             // just past the new count

    // Random: phases that grow, drain or churn the list, so it swings between empty and full.
    mode = 0;
    span = 0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(30, 60);
      end
      span--;
      r = $urandom_range(0, 99);
      case (mode)
        0: f = (r < 50) ? FUNC_APPEND : (r < 85) ? FUNC_INSERT : (r < 93) ? FUNC_READ
                                                                          : FUNC_REMOVE;
        1: f = (r < 55) ? FUNC_REMOVE : (r < 80) ? FUNC_READ : (r < 90) ? FUNC_APPEND
                                                                        : FUNC_INSERT;
        default: f = 2'($urandom_range(0, 3));
      endcase
      // Mostly legal positions; the rest anywhere in the 5-bit field.
      if ($urandom_range(0, 99) < 12)
        pos = $urandom_range(0, 31);
      else if (f == FUNC_INSERT)
        pos = $urandom_range(0, plan_count);
      else if (plan_count > 0)
        pos = $urandom_range(0, plan_count - 1);
      else
        pos = 0;
      r = $urandom_range(0, 99);
      v = (r < 6) ? 32'h0 : (r < 12) ? 32'hFFFF_FFFF : $urandom;
      queue_op(f, pos, v);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent and every owed word back, then let the pipe settle.
    @(posedge clk);
    while (ops_to_send.size() > 0 || req_valid || results_owed.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_owed.size() != 0) begin
      $error("%0d result words never arrived", results_owed.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASS positional_insert_remove_list_unit");
    else
      $display("FAIL positional_insert_remove_list_unit");
    $finish;
  end

endmodule
